@@ rtl/path_segment_geometry_top_defines.svh @@
// assertion macros for the path segment geometry block
`ifndef PATH_SEGMENT_GEOMETRY_TOP_DEFINES_SVH
`define PATH_SEGMENT_GEOMETRY_TOP_DEFINES_SVH

// a condition implies another in the same cycle
`define PSG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// a condition implies another in the next cycle
`define PSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ rtl/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// types and constants shared by the path segment geometry block
// ----------------------------------------------------------------------------
`default_nettype none
package psg_pkg;

  localparam int MaxPoints = 4096;
  localparam int CntW      = $clog2(MaxPoints) + 1;
  localparam int LenW      = 17;
  localparam int SumW      = LenW + CntW - 1;
  localparam int QW        = 31;

  // divider operand select
  localparam logic [1:0] SelX   = 2'd0;
  localparam logic [1:0] SelY   = 2'd1;
  localparam logic [1:0] SelZ   = 2'd2;
  localparam logic [1:0] SelAvg = 2'd3;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic               path_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [16:0]        seg_len;
    logic [16:0]        avg_step;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
    logic               end_of_path;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;     // capture item, update state / differences
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic [1:0] div_sel;  // direction axis or average
    logic       div_step;
    logic       div_store;
    logic       close;    // path end bookkeeping
  } psg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seg;
    logic is_end;
  } psg_sts_t;

endpackage
`default_nettype wire

@@ rtl/psg_ctrl.sv @@
// ----------------------------------------------------------------------------
// psg_ctrl
// sequencer: load, square root iterations, up to four divisions, result handoff
// ----------------------------------------------------------------------------
`default_nettype none
`include "path_segment_geometry_top_defines.svh"
module psg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output psg_pkg::psg_cmd_t      cmd,
  input  wire psg_pkg::psg_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] sel_r, sel_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.seg) begin
          cmd.sqrt_init = 1'b1;
          cnt_nxt   = 6'd18;
          state_nxt = S_SQRT;
        end else if (sts.is_end) begin
          sel_nxt     = psg_pkg::SelAvg;
          cmd.div_sel = psg_pkg::SelAvg;
          cmd.div_init = 1'b1;
          cnt_nxt     = 6'(psg_pkg::QW);
          state_nxt   = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          sel_nxt   = psg_pkg::SelX;
          state_nxt = S_DIV;
          cnt_nxt   = 6'd0;
        end
      end
      S_DIV: begin
        if (cnt_r == 6'd0) begin
          // first cycle of a division after sqrt or previous division
          cmd.div_init = 1'b1;
          cnt_nxt = 6'(psg_pkg::QW);
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            cmd.div_store = 1'b1;
            if (sel_r == psg_pkg::SelAvg || (sel_r == psg_pkg::SelZ && !sts.is_end)) begin
              state_nxt = S_OUT;
            end else begin
              sel_nxt = sel_r + 2'd1;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.close = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  `PSG_ASSERT_IMP(a_no_accept_busy, cmd.load, state_r == S_IDLE)
  `PSG_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)
  `PSG_ASSERT_NEXT(a_load_chk, cmd.load, state_r == S_CHK)

endmodule
`default_nettype wire

@@ rtl/psg_dp.sv @@
// ----------------------------------------------------------------------------
// psg_dp
// path state, squared distance, shared bit-serial root and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module psg_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire psg_pkg::in_item_t in_data,
  input  wire psg_pkg::psg_cmd_t cmd,
  output psg_pkg::psg_sts_t      sts,
  output psg_pkg::out_item_t     out_data
);

  localparam int CW = psg_pkg::CntW;
  localparam int SW = psg_pkg::SumW;
  localparam int QW = psg_pkg::QW;

  logic               have_prev_r;
  logic signed [15:0] prev_r [3];
  logic signed [15:0] bmin_r [3];
  logic signed [15:0] bmax_r [3];
  logic [SW-1:0]      sum_r;
  logic [CW-1:0]      count_r;
  logic signed [16:0] d_r [3];
  logic               seg_r, end_r;

  // square root
  logic [35:0] rem_r;
  logic [35:0] root_r;
  logic [35:0] bit_r;
  // divider
  logic [QW-1:0] quo_r;
  logic [QW+17:0] drem_r;
  logic [SW-1:0]  den_r;
  logic [QW-1:0] divq_nxt;
  logic [QW+17:0] drem_nxt;

  psg_pkg::out_item_t res_r;

  logic        diff;
  logic [35:0] sq_nxt;
  logic [16:0] mag [3];

  assign sts.seg    = seg_r;
  assign sts.is_end = end_r;
  assign out_data   = res_r;

  always_comb begin
    logic signed [15:0] p [3];
    p[0] = in_data.x_coord;
    p[1] = in_data.y_coord;
    p[2] = in_data.z_coord;
    diff = (p[0] != prev_r[0]) || (p[1] != prev_r[1]) || (p[2] != prev_r[2]);
    sq_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_r[i][16] ? 17'(-d_r[i]) : 17'(d_r[i]);
      sq_nxt = sq_nxt + 36'(34'(mag[i]) * 34'(mag[i]));
    end
  end

  // one restoring division step
  always_comb begin
    logic [QW+17:0] t;
    t = {drem_r[QW+16:0], 1'b0};
    if (t[QW+17:QW] >= {1'b0, 17'(den_r)} ) begin
      drem_nxt = {t[QW+17:QW] - {1'b0, 17'(den_r)}, t[QW-1:0]};
      divq_nxt = {quo_r[QW-2:0], 1'b1};
    end else begin
      drem_nxt = t;
      divq_nxt = {quo_r[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      sum_r   <= '0;
      count_r <= '0;
      seg_r   <= 1'b0;
      end_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
        bmin_r[i] <= '0;
        bmax_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        end_r <= in_data.path_end;
        seg_r <= 1'b0;
        if (!have_prev_r) begin
          have_prev_r <= 1'b1;
          sum_r   <= '0;
          count_r <= '0;
          prev_r[0] <= in_data.x_coord; bmin_r[0] <= in_data.x_coord;
          bmax_r[0] <= in_data.x_coord;
          prev_r[1] <= in_data.y_coord; bmin_r[1] <= in_data.y_coord;
          bmax_r[1] <= in_data.y_coord;
          prev_r[2] <= in_data.z_coord; bmin_r[2] <= in_data.z_coord;
          bmax_r[2] <= in_data.z_coord;
        end else if (diff && ({1'b0, count_r} + (CW+1)'(1) <
                              (CW+1)'(psg_pkg::MaxPoints))) begin
          logic signed [15:0] p [3];
          p[0] = in_data.x_coord;
          p[1] = in_data.y_coord;
          p[2] = in_data.z_coord;
          seg_r   <= 1'b1;
          count_r <= count_r + 1'b1;
          for (int i = 0; i < 3; i++) begin
            d_r[i] <= 17'(p[i]) - 17'(prev_r[i]);
            prev_r[i] <= p[i];
            if (p[i] < bmin_r[i]) bmin_r[i] <= p[i];
            if (p[i] > bmax_r[i]) bmax_r[i] <= p[i];
          end
        end
      end
      if (cmd.div_store && cmd.div_sel == psg_pkg::SelZ) begin
        sum_r <= sum_r + SW'(root_r[16:0]);
      end
      if (cmd.close && end_r) begin
        have_prev_r <= 1'b0;
        sum_r   <= '0;
        count_r <= '0;
      end
    end
  end

  // payload and arithmetic units
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_r  <= sq_nxt;
      root_r <= '0;
      bit_r  <= 36'h1 << 34;
    end
    if (cmd.sqrt_step) begin
      if (rem_r >= root_r + bit_r) begin
        rem_r  <= rem_r - (root_r + bit_r);
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.load) begin
      res_r <= '0;
      root_r <= '0;
    end
    if (cmd.div_init) begin
      quo_r <= '0;
      if (cmd.div_sel == psg_pkg::SelAvg) begin
        den_r  <= SW'(count_r);
        drem_r <= (QW+18)'(sum_r);
      end else begin
        den_r  <= SW'(root_r[16:0]);
        drem_r <= (QW+18)'({mag[cmd.div_sel], 14'd0});
      end
    end
    if (cmd.div_step) begin
      quo_r  <= divq_nxt;
      drem_r <= drem_nxt;
    end
    if (cmd.div_store) begin
      logic [QW-1:0] q;
      logic [15:0] qc;
      q  = divq_nxt;
      qc = (q > QW'(16384)) ? 16'd16384 : q[15:0];
      if (cmd.div_sel == psg_pkg::SelAvg) begin
        res_r.avg_step <= (count_r == '0) ? 17'd0 : q[16:0];
        res_r.min_x <= bmin_r[0]; res_r.min_y <= bmin_r[1];
        res_r.min_z <= bmin_r[2];
        res_r.max_x <= bmax_r[0]; res_r.max_y <= bmax_r[1];
        res_r.max_z <= bmax_r[2];
        res_r.end_of_path <= 1'b1;
      end else begin
        res_r.seg_len <= root_r[16:0];
        if (d_r[cmd.div_sel][16]) qc = 16'(-qc);
        unique case (cmd.div_sel)
          psg_pkg::SelX: res_r.dir_x <= qc;
          psg_pkg::SelY: res_r.dir_y <= qc;
          default: res_r.dir_z <= qc;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/path_segment_geometry_top.sv @@
// ----------------------------------------------------------------------------
// path_segment_geometry_top
// per-point segment length, unit direction and path summary
// ----------------------------------------------------------------------------
// channel | direction | payload
// in_     | input     | in_item_t point and path_end flag
// out_    | output    | out_item_t direction, length, summary
// one item at a time: a dropped point goes from load to a check and back to idle;
// a lone end point runs the average division; a segment takes load, check, root
// steps, three divisions and output, and the average on path end; one shared divider
// synchronous active-low reset clears path state; in_stall is high while busy
// a stalled result holds in the output register until taken
`default_nettype none
module path_segment_geometry_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire psg_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psg_pkg::out_item_t      out_data
);

  psg_pkg::psg_cmd_t cmd;
  psg_pkg::psg_sts_t sts;

  psg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  psg_dp u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_data
  );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks path_segment_geometry_top against a behavioral predictor of segment
// length, unit direction, bounding box and average step, under random idling
// ----------------------------------------------------------------------------
module tb_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  psg_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  psg_pkg::out_item_t out_data;

  path_segment_geometry_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  psg_pkg::in_item_t  point_q[$];
  psg_pkg::out_item_t geom_q[$];
  int        errors = 0;
  int        send_idle_pct = 31;
  int        recv_idle_pct = 74;
  bit        hold_go = 1'b0;
  bit        hold_on = 1'b0;

  // predictor state
  bit                 pr_have;
  logic signed [15:0] pr_prev [3];
  logic signed [15:0] pr_min [3];
  logic signed [15:0] pr_max [3];
  logic [63:0]        pr_sum;
  int unsigned        pr_count;

  function automatic logic [16:0] root_floor(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[16:0];
  endfunction

  function automatic logic signed [15:0] unit_dir(input int d, input logic [16:0] len);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = (len != 0) ? (mag <<< 14) / len : 0;
    if (q > 16384) q = 16384;
    return (d < 0) ? -q[15:0] : q[15:0];
  endfunction

  task automatic predict_geometry(input psg_pkg::in_item_t it);
    logic signed [15:0] p [3];
    int                 d [3];
    bit                 seg;
    logic [63:0]        sq;
    logic [16:0]        len;
    psg_pkg::out_item_t r;
    p[0] = it.x_coord; p[1] = it.y_coord; p[2] = it.z_coord;
    seg = 0; len = 0; sq = 0;
    d[0] = 0; d[1] = 0; d[2] = 0;
    if (!pr_have) begin
      for (int i = 0; i < 3; i++) begin
        pr_prev[i] = p[i]; pr_min[i] = p[i]; pr_max[i] = p[i];
      end
      pr_have = 1; pr_sum = 0; pr_count = 0;
    end else if ((p[0] != pr_prev[0] || p[1] != pr_prev[1] || p[2] != pr_prev[2]) &&
                 pr_count + 1 < psg_pkg::MaxPoints) begin
      for (int i = 0; i < 3; i++) begin
        d[i] = int'(p[i]) - int'(pr_prev[i]);
        sq += 64'(longint'(d[i]) * longint'(d[i]));
      end
      len = root_floor(sq);
      seg = 1;
      for (int i = 0; i < 3; i++) begin
        if (p[i] < pr_min[i]) pr_min[i] = p[i];
        if (p[i] > pr_max[i]) pr_max[i] = p[i];
        pr_prev[i] = p[i];
      end
      pr_sum += len;
      pr_count++;
    end
    if (!seg && !it.path_end) return;
    r = '0;
    if (seg) begin
      r.dir_x = unit_dir(d[0], len);
      r.dir_y = unit_dir(d[1], len);
      r.dir_z = unit_dir(d[2], len);
      r.seg_len = len;
    end
    if (it.path_end) begin
      r.avg_step = (pr_count != 0) ? 17'(pr_sum / pr_count) : '0;
      r.min_x = pr_min[0]; r.min_y = pr_min[1]; r.min_z = pr_min[2];
      r.max_x = pr_max[0]; r.max_y = pr_max[1]; r.max_z = pr_max[2];
      r.end_of_path = 1;
      pr_have = 0; pr_sum = 0; pr_count = 0;
    end
    geom_q.insert(geom_q.size(), r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_geometry(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= point_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_on <= 1'b0;
  end

  // receiver stall and monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (geom_q.size() == 0) begin
          $error("unexpected result %p", out_data);
          errors++;
        end else begin
          psg_pkg::out_item_t e;
          e = geom_q.pop_front();
          if (e.dir_x !== out_data.dir_x) begin
            $error("dir_x exp %0d got %0d", e.dir_x, out_data.dir_x); errors++;
          end
          if (e.dir_y !== out_data.dir_y) begin
            $error("dir_y exp %0d got %0d", e.dir_y, out_data.dir_y); errors++;
          end
          if (e.dir_z !== out_data.dir_z) begin
            $error("dir_z exp %0d got %0d", e.dir_z, out_data.dir_z); errors++;
          end
          if (e.seg_len !== out_data.seg_len) begin
            $error("seg_len exp %0d got %0d", e.seg_len, out_data.seg_len); errors++;
          end
          if (e.avg_step !== out_data.avg_step) begin
            $error("avg_step exp %0d got %0d", e.avg_step, out_data.avg_step); errors++;
          end
          if (e.min_x !== out_data.min_x) begin
            $error("min_x exp %0d got %0d", e.min_x, out_data.min_x); errors++;
          end
          if (e.min_y !== out_data.min_y) begin
            $error("min_y exp %0d got %0d", e.min_y, out_data.min_y); errors++;
          end
          if (e.min_z !== out_data.min_z) begin
            $error("min_z exp %0d got %0d", e.min_z, out_data.min_z); errors++;
          end
          if (e.max_x !== out_data.max_x) begin
            $error("max_x exp %0d got %0d", e.max_x, out_data.max_x); errors++;
          end
          if (e.max_y !== out_data.max_y) begin
            $error("max_y exp %0d got %0d", e.max_y, out_data.max_y); errors++;
          end
          if (e.max_z !== out_data.max_z) begin
            $error("max_z exp %0d got %0d", e.max_z, out_data.max_z); errors++;
          end
          if (e.end_of_path !== out_data.end_of_path) begin
            $error("end_of_path exp %0d got %0d", e.end_of_path, out_data.end_of_path);
            errors++;
          end
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic psg_pkg::in_item_t mk_point(input logic [15:0] x,
                                                 input logic [15:0] y,
                                                 input logic [15:0] z, input bit e);
    psg_pkg::in_item_t it;
    it.x_coord = x; it.y_coord = y; it.z_coord = z; it.path_end = e;
    return it;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  task automatic add_random_path();
    int          n;
    logic [15:0] x, y, z;
    n = $urandom_range(9);
    x = rand_coord(); y = rand_coord(); z = rand_coord();
    for (int k = 0; k <= n; k++) begin
      if ($urandom_range(9) != 0) begin
        // small step mostly, occasionally a full jump
        if ($urandom_range(4) == 0) begin
          x = rand_coord(); y = rand_coord(); z = rand_coord();
        end else begin
          x += 16'($urandom_range(40)) - 16'd20;
          y += 16'($urandom_range(40)) - 16'd20;
          z += 16'($urandom_range(40)) - 16'd20;
        end
      end
      point_q.insert(point_q.size(), mk_point(x, y, z, (k == n)));
    end
  endtask

  task automatic add_point(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input bit e);
    point_q.insert(point_q.size(), mk_point(x, y, z, e));
  endtask

  task automatic wait_drained();
    while (point_q.size() != 0 || in_valid || geom_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    pr_have = 0; pr_sum = 0; pr_count = 0;
    for (int i = 0; i < 3; i++) begin
      pr_prev[i] = 0; pr_min[i] = 0; pr_max[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: lone end point, repeat, extremes, diagonal, axis moves
    add_point(16'd5, 16'd5, 16'd5, 1);
    add_point(16'h8000, 16'h8000, 16'h8000, 0);
    add_point(16'h8000, 16'h8000, 16'h8000, 0);
    add_point(16'h7fff, 16'h7fff, 16'h7fff, 0);
    add_point(16'h8000, 16'h7fff, 16'h8000, 0);
    add_point(16'h8000, 16'h7fff, 16'h8000, 1);
    add_point(16'd0, 16'd0, 16'd0, 0);
    add_point(16'd1, 16'd0, 16'd0, 0);
    add_point(16'd1, 16'hffff, 16'd0, 0);
    add_point(16'd1, 16'hffff, 16'd7, 0);
    add_point(16'd4, 16'd3, 16'd7, 0);
    add_point(16'hffff, 16'hffff, 16'hffff, 1);
    add_point(16'h1234, 16'h5678, 16'h9abc, 0);
    add_point(16'h1234, 16'h5678, 16'h9abc, 1);
    wait_drained();
    while (point_q.size() < 560) add_random_path();
    wait_drained();
    send_idle_pct = 74; recv_idle_pct = 31;
    while (point_q.size() < 560) add_random_path();
    // long receiver hold-off while points keep coming
    hold_go = 1'b1;
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    while (point_q.size() < 560) add_random_path();
    wait_drained();
    if (errors == 0) begin
      $display("path_segment_geometry_top test passed");
    end else begin
      $display("path_segment_geometry_top test failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("path_segment_geometry_top test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/psg_pkg.sv
rtl/psg_ctrl.sv
rtl/psg_dp.sv
rtl/path_segment_geometry_top.sv
sim/tb_top.sv
